[design/cvdr_pkg.sv]
`timescale 1ns / 1ps

package cvdr_pkg;

  localparam int unsigned MV_W     = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DUTY_W   = 10;
  localparam int unsigned PERIOD_W = 8;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PROD_W     = 23;

  localparam int unsigned PCT_FULL = 100;

  localparam logic [MV_W-1:0]     TARGET_RST  = MV_W'(5000);
  localparam logic [MV_W-1:0]     RIPPLE_RST  = MV_W'(2200);
  localparam logic [MV_W-1:0]     STEP_RST    = MV_W'(1);
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = PERIOD_W'(5);
  localparam logic [PCT_W-1:0]    SNUB_RST    = PCT_W'(3);
  localparam logic [DUTY_W-1:0]   FLOOR_RST   = '0;
  localparam logic [DUTY_W-1:0]   CEILING_RST = DUTY_W'(1023);
  localparam logic [PROD_W-1:0]   PROD_RST    = PROD_W'(5000 * (100 - 3));

  localparam int unsigned RESET_PREV_MV_DEF = 20000;

  typedef enum logic [1:0] {
    MODE_SOFT = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SNUB = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET  = 3'd0,
    CFG_RIPPLE  = 3'd1,
    CFG_STEP    = 3'd2,
    CFG_PERIOD  = 3'd3,
    CFG_SNUB    = 3'd4,
    CFG_FLOOR   = 3'd5,
    CFG_CEILING = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic              restart;
    logic              output_enable;
    logic [MV_W-1:0]   output_mv;
    logic [TIME_W-1:0] time_ticks;
  } in_word_t;

endpackage

[design/cvdr_if.sv]
`timescale 1ns / 1ps

interface cvdr_in_if;
  logic                           valid;
  logic                           ready;
  logic                           restart;
  logic                           output_enable;
  logic [cvdr_pkg::MV_W-1:0]      output_mv;
  logic [cvdr_pkg::TIME_W-1:0]    time_ticks;

  modport source (output valid, output restart, output output_enable, output output_mv,
                  output time_ticks, input ready);
  modport sink (input valid, input restart, input output_enable, input output_mv,
                input time_ticks, output ready);
endinterface

interface cvdr_out_if;
  logic                           valid;
  logic                           ready;
  logic [cvdr_pkg::DUTY_W-1:0]    duty_count;
  logic [1:0]                     reg_mode;
  logic                           power_fault;

  modport source (output valid, output duty_count, output reg_mode, output power_fault,
                  input ready);
  modport sink (input valid, input duty_count, input reg_mode, input power_fault,
                output ready);
endinterface

[design/cv_duty_regulator_softstart.sv]
`timescale 1ns / 1ps

// channel   dir  word
// in_i      in   restart, output_enable, output_mv, time_ticks
// out_o     out  duty_count, reg_mode, power_fault
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// one word per cycle sustained while out_o.ready holds; a result is shown once its input word
// has passed the input register, then one pass of compare logic into the state registers
// the snub threshold product is registered when target or snub percent is written
// rst_ni clears regulator state and config to defaults, no clearing pass
// a stalled result holds; one more input word is buffered, then in_i.ready drops

module cv_duty_regulator_softstart #(
  parameter int unsigned RESET_PREV_MV = cvdr_pkg::RESET_PREV_MV_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cvdr_in_if.sink                          in_i,
  cvdr_out_if.source                       out_o,
  input  logic                             cfg_we_i,
  input  logic [cvdr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cvdr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import cvdr_pkg::*;

  localparam logic [MV_W-1:0] PREV_RST = MV_W'(RESET_PREV_MV);

  logic [MV_W-1:0]     target_q, ripple_q, step_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PCT_W-1:0]    snub_q;
  logic [DUTY_W-1:0]   floor_q, ceiling_q;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [MV_W-1:0]     mul_a;
  logic [PCT_W-1:0]    mul_b;

  logic     in_vld_q;
  in_word_t in_word_q;
  logic     out_vld_q;
  logic     advance, process;

  mode_e             mode_q, mode_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic              fault_q, fault_d;
  logic [MV_W-1:0]   prev_q, prev_d;
  logic [TIME_W-1:0] last_q, last_d;

  logic [MV_W:0]     mv_ext, trip_lvl, rise_lvl, mv_inc;
  logic [PROD_W-1:0] mv_scaled;
  logic [TIME_W-1:0] elapsed;
  logic              over, below, lt, gt, hold;
  mode_e             m1, m2;
  logic [DUTY_W-1:0] d1, d2;
  logic              f1, f2;

  // snub threshold product, kept in step with the config registers
  always_comb begin
    mul_a = (cfg_we_i && cfg_idx_i == CFG_TARGET) ? cfg_data_i : target_q;
    mul_b = (cfg_we_i && cfg_idx_i == CFG_SNUB) ? cfg_data_i[PCT_W-1:0] : snub_q;
    if (mul_b < PCT_W'(PCT_FULL)) begin
      prod_d = PROD_W'(mul_a) * PROD_W'(PCT_W'(PCT_FULL) - mul_b);
    end else begin
      prod_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= TARGET_RST;
      ripple_q  <= RIPPLE_RST;
      step_q    <= STEP_RST;
      period_q  <= PERIOD_RST;
      snub_q    <= SNUB_RST;
      floor_q   <= FLOOR_RST;
      ceiling_q <= CEILING_RST;
      prod_q    <= PROD_RST;
    end else begin
      prod_q <= prod_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TARGET:  target_q  <= cfg_data_i;
          CFG_RIPPLE:  ripple_q  <= cfg_data_i;
          CFG_STEP:    step_q    <= cfg_data_i;
          CFG_PERIOD:  period_q  <= cfg_data_i[PERIOD_W-1:0];
          CFG_SNUB:    snub_q    <= cfg_data_i[PCT_W-1:0];
          CFG_FLOOR:   floor_q   <= cfg_data_i[DUTY_W-1:0];
          CFG_CEILING: ceiling_q <= cfg_data_i[DUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign advance    = !out_vld_q || out_o.ready;
  assign process    = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_word_q <= '{restart: in_i.restart, output_enable: in_i.output_enable,
                     output_mv: in_i.output_mv, time_ticks: in_i.time_ticks};
    end
  end

  // one tick of regulation
  always_comb begin
    mv_ext    = {1'b0, in_word_q.output_mv};
    trip_lvl  = {1'b0, target_q} + {1'b0, ripple_q};
    rise_lvl  = {1'b0, prev_q} + {1'b0, step_q};
    mv_inc    = mv_ext + (MV_W+1)'(1);
    mv_scaled = {mv_inc, 6'b0} + {1'b0, mv_inc, 5'b0} + {4'b0, mv_inc, 2'b0};
    elapsed   = in_word_q.time_ticks - last_q;
    over  = (mode_q == MODE_ON) && (mv_ext > trip_lvl);
    below = (snub_q < PCT_W'(PCT_FULL)) && (mv_scaled <= prod_q);
    lt    = in_word_q.output_mv < target_q;
    gt    = in_word_q.output_mv > target_q;

    m1 = over ? MODE_SNUB : mode_q;
    d1 = over ? '0 : duty_q;
    f1 = over ? 1'b1 : fault_q;

    m2 = m1;
    d2 = d1;
    f2 = f1;
    hold = !in_word_q.output_enable || (m1 == MODE_SNUB && !below);
    if (m1 == MODE_SNUB && below) begin
      if (snub_q == '0) begin
        m2 = MODE_ON;
        f2 = 1'b0;
      end else begin
        m2 = MODE_SOFT;
        d2 = '0;
      end
    end

    mode_d  = m1;
    duty_d  = d1;
    fault_d = f1;
    prev_d  = prev_q;
    last_d  = last_q;

    if (in_word_q.restart) begin
      mode_d  = MODE_SOFT;
      duty_d  = '0;
      fault_d = 1'b0;
      prev_d  = PREV_RST;
    end else if (!hold) begin
      mode_d  = m2;
      duty_d  = d2;
      fault_d = f2;
      prev_d  = in_word_q.output_mv;
      if (lt && d2 < ceiling_q) begin
        if (m2 == MODE_SOFT) begin
          if (elapsed >= TIME_W'(period_q)) begin
            last_d = in_word_q.time_ticks;
            if (mv_ext <= rise_lvl) begin
              duty_d = d2 + DUTY_W'(1);
            end
          end
        end else begin
          duty_d = d2 + DUTY_W'(1);
        end
      end else if (gt && d2 > floor_q) begin
        duty_d = d2 - DUTY_W'(1);
      end
      if (m2 == MODE_SOFT && (gt || !lt || duty_d == ceiling_q)) begin
        mode_d  = MODE_ON;
        fault_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_SOFT;
      duty_q  <= '0;
      fault_q <= 1'b0;
      prev_q  <= PREV_RST;
      last_q  <= '0;
    end else if (process) begin
      mode_q  <= mode_d;
      duty_q  <= duty_d;
      fault_q <= fault_d;
      prev_q  <= prev_d;
      last_q  <= last_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.duty_count  = duty_q;
  assign out_o.reg_mode    = mode_q;
  assign out_o.power_fault = fault_q;

endmodule

[design/cvdr_chk.sv]
`timescale 1ns / 1ps

module cvdr_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [cvdr_pkg::DUTY_W-1:0]   duty_count_i,
  input logic [1:0]                    reg_mode_i,
  input logic                          power_fault_i
);
  import cvdr_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(duty_count_i)
      && $stable(reg_mode_i) && $stable(power_fault_i))
    else $error("result word changed while stalled");

  // input side only backs up behind a stalled result
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready with empty output");

  // fault is never reported while regulation is on
  a_fault_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && power_fault_i |-> reg_mode_i != MODE_ON)
    else $error("fault reported while on");

  // snub keeps the duty at zero
  a_snub_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && reg_mode_i == MODE_SNUB |-> duty_count_i == '0)
    else $error("nonzero duty in snub");

endmodule

bind cv_duty_regulator_softstart cvdr_chk u_cvdr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .duty_count_i  (out_o.duty_count),
  .reg_mode_i    (out_o.reg_mode),
  .power_fault_i (out_o.power_fault)
);

[verif/tb_cv_duty_regulator_softstart.sv]
`timescale 1ns / 1ps

module tb_cv_duty_regulator_softstart;
  import cvdr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 500;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned PHASE_TICKS    = 90;
  localparam logic [MV_W-1:0] PRESET_MV  = MV_W'(RESET_PREV_MV_DEF);

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    mode_e             mode;
    logic              fault;
  } reg_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  cvdr_in_if  in_if ();
  cvdr_out_if out_if ();

  cv_duty_regulator_softstart u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // register shadow
  logic [MV_W-1:0]     target_mv;
  logic [MV_W-1:0]     ripple_mv;
  logic [MV_W-1:0]     step_mv;
  logic [PERIOD_W-1:0] period_ticks;
  logic [PCT_W-1:0]    snub_pct;
  logic [DUTY_W-1:0]   floor_duty;
  logic [DUTY_W-1:0]   ceil_duty;

  // regulator state
  mode_e               mode_q;
  logic [DUTY_W-1:0]   duty_q;
  logic [MV_W-1:0]     prev_mv_q;
  logic [TIME_W-1:0]   soft_time_q;
  logic                fault_q;

  in_word_t    tick_q[$];
  in_word_t    tick_word;
  reg_out_t    regulator_outputs_q[$];
  reg_out_t    head_out;
  int unsigned ticks_sent, ticks_taken, outputs_seen, errors;
  int unsigned gap_left, stall_left, quiet_cycles;
  int unsigned settings, snubs, restarts;
  bit          send_steady, take_steady;

  function automatic reg_out_t step_regulator(in_word_t w);
    logic [MV_W:0]     trip_mv;
    logic [MV_W:0]     rise_mv;
    logic [TIME_W-1:0] elapsed;
    int unsigned       sag_mv;
    logic              held;
    trip_mv = {1'b0, target_mv} + {1'b0, ripple_mv};
    rise_mv = {1'b0, prev_mv_q} + {1'b0, step_mv};
    elapsed = w.time_ticks - soft_time_q;
    sag_mv  = 0;
    if (snub_pct < PCT_FULL) sag_mv = target_mv * (PCT_FULL - snub_pct) / PCT_FULL;
    held = 1'b0;
    if (w.restart) begin
      duty_q    = '0;
      mode_q    = MODE_SOFT;
      prev_mv_q = PRESET_MV;
      fault_q   = 1'b0;
      restarts++;
    end else begin
      if (mode_q == MODE_ON && {1'b0, w.output_mv} > trip_mv) begin
        duty_q  = '0;
        mode_q  = MODE_SNUB;
        fault_q = 1'b1;
        snubs++;
      end
      if (w.output_enable) begin
        if (mode_q == MODE_SNUB) begin
          if (w.output_mv < sag_mv) begin
            if (snub_pct == '0) begin
              mode_q  = MODE_ON;
              fault_q = 1'b0;
            end else begin
              duty_q = '0;
              mode_q = MODE_SOFT;
            end
          end else begin
            held = 1'b1;
          end
        end
        if (!held) begin
          if (w.output_mv < target_mv && duty_q < ceil_duty) begin
            if (mode_q == MODE_SOFT) begin
              if (elapsed >= TIME_W'(period_ticks)) begin
                soft_time_q = w.time_ticks;
                if ({1'b0, w.output_mv} <= rise_mv) duty_q = duty_q + 1'b1;
              end
            end else begin
              duty_q = duty_q + 1'b1;
            end
          end else if (w.output_mv > target_mv && duty_q > floor_duty) begin
            duty_q = duty_q - 1'b1;
            if (mode_q == MODE_SOFT) begin
              mode_q  = MODE_ON;
              fault_q = 1'b0;
            end
          end
          if ((w.output_mv >= target_mv || duty_q == ceil_duty) && mode_q == MODE_SOFT) begin
            mode_q  = MODE_ON;
            fault_q = 1'b0;
          end
          prev_mv_q = w.output_mv;
        end
      end
    end
    return '{duty: duty_q, mode: mode_q, fault: fault_q};
  endfunction

  task automatic flag_mismatch(string field, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch on %s: got %0d want %0d (result %0d)", field, got, want,
             outputs_seen);
  endtask

  task automatic push_tick(logic restart, logic enable, logic [MV_W-1:0] mv,
                           logic [TIME_W-1:0] ticks);
    tick_q.push_back('{restart: restart, output_enable: enable, output_mv: mv,
                       time_ticks: ticks});
    ticks_sent++;
  endtask

  task automatic settle();
    while (ticks_taken != ticks_sent || regulator_outputs_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_TARGET:  target_mv    = val;
      CFG_RIPPLE:  ripple_mv    = val;
      CFG_STEP:    step_mv      = val;
      CFG_PERIOD:  period_ticks = val[PERIOD_W-1:0];
      CFG_SNUB:    snub_pct     = val[PCT_W-1:0];
      CFG_FLOOR:   floor_duty   = val[DUTY_W-1:0];
      CFG_CEILING: ceil_duty    = val[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_limits(int unsigned target, int unsigned ripple, int unsigned step,
                                int unsigned period, int unsigned snub, int unsigned lo,
                                int unsigned hi);
    write_reg(CFG_TARGET, CFG_DATA_W'(target));
    write_reg(CFG_RIPPLE, CFG_DATA_W'(ripple));
    write_reg(CFG_STEP, CFG_DATA_W'(step));
    write_reg(CFG_PERIOD, CFG_DATA_W'(period));
    write_reg(CFG_SNUB, CFG_DATA_W'(snub));
    write_reg(CFG_FLOOR, CFG_DATA_W'(lo));
    write_reg(CFG_CEILING, CFG_DATA_W'(hi));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // mostly voltages around the regulation points, some noise and spikes
  task automatic random_phase(int unsigned count, logic [TIME_W-1:0] start_ticks);
    logic [TIME_W-1:0] now;
    int                sag;
    int                trip;
    int                v;
    int unsigned       pick;
    now  = start_ticks;
    sag  = (snub_pct < PCT_FULL) ? int'(target_mv * (PCT_FULL - snub_pct) / PCT_FULL) : 0;
    trip = int'(target_mv) + int'(ripple_mv);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        v = int'(target_mv) + int'($urandom_range(0, 600)) - 300;
      end else if (pick < 55) begin
        v = $urandom_range(0, target_mv);
      end else if (pick < 65) begin
        v = trip + 1 + int'($urandom_range(0, 2000));
      end else if (pick < 75) begin
        v = $urandom_range(0, 16'hFFFF);
      end else begin
        case ($urandom_range(0, 5))
          0: v = target_mv;
          1: v = trip;
          2: v = trip + 1;
          3: v = sag - 1;
          4: v = sag;
          default: v = int'(target_mv) - 1;
        endcase
      end
      if (v < 0) v = 0;
      if (v > 16'hFFFF) v = 16'hFFFF;
      if ($urandom_range(0, 19) == 0) now = $urandom;
      else now = now + TIME_W'($urandom_range(0, period_ticks + 2));
      push_tick($urandom_range(0, 99) < 3, $urandom_range(0, 99) < 88, MV_W'(v), now);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        regulator_outputs_q.push_back(step_regulator(tick_word));
        ticks_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          tick_word = tick_q.pop_front();
          in_if.valid         <= 1'b1;
          in_if.restart       <= tick_word.restart;
          in_if.output_enable <= tick_word.output_enable;
          in_if.output_mv     <= tick_word.output_mv;
          in_if.time_ticks    <= tick_word.time_ticks;
          if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
          gap_left = send_steady ? 0 : $urandom_range(0, 3);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        outputs_seen++;
        if (regulator_outputs_q.size() == 0) begin
          flag_mismatch("word with nothing outstanding", out_if.duty_count, 0);
        end else begin
          head_out = regulator_outputs_q.pop_front();
          if (out_if.duty_count !== head_out.duty)
            flag_mismatch("duty_count", out_if.duty_count, head_out.duty);
          if (out_if.reg_mode !== head_out.mode)
            flag_mismatch("reg_mode", out_if.reg_mode, head_out.mode);
          if (out_if.power_fault !== head_out.fault)
            flag_mismatch("power_fault", out_if.power_fault, head_out.fault);
        end
        if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
        stall_left = take_steady ? 0 : $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding", WATCHDOG_LIMIT,
               regulator_outputs_q.size());
      $display("[cv_duty_regulator_softstart] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned lo_duty;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_TARGET;
    cfg_data            = '0;
    in_if.valid         = 1'b0;
    in_if.restart       = 1'b0;
    in_if.output_enable = 1'b0;
    in_if.output_mv     = '0;
    in_if.time_ticks    = '0;
    out_if.ready        = 1'b0;
    target_mv    = TARGET_RST;
    ripple_mv    = RIPPLE_RST;
    step_mv      = STEP_RST;
    period_ticks = PERIOD_RST;
    snub_pct     = SNUB_RST;
    floor_duty   = FLOOR_RST;
    ceil_duty    = CEILING_RST;
    mode_q       = MODE_SOFT;
    duty_q       = '0;
    prev_mv_q    = PRESET_MV;
    soft_time_q  = '0;
    fault_q      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: trip above 7200 mv, snub ends below 4850 mv
    push_tick(1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    push_tick(1'b0, 1'b1, 16'd0, 32'd0);
    push_tick(1'b0, 1'b1, 16'd0, 32'd5);
    push_tick(1'b0, 1'b1, 16'd100, 32'd10);
    push_tick(1'b0, 1'b1, 16'd100, 32'd12);
    push_tick(1'b0, 1'b0, 16'hFFFF, 32'd13);
    push_tick(1'b0, 1'b1, 16'd5000, 32'd20);
    push_tick(1'b0, 1'b1, 16'd4999, 32'd21);
    push_tick(1'b0, 1'b1, 16'd5001, 32'd22);
    push_tick(1'b0, 1'b1, 16'd7200, 32'd23);
    push_tick(1'b0, 1'b0, 16'd7201, 32'd24);
    push_tick(1'b0, 1'b1, 16'd4850, 32'd25);
    push_tick(1'b0, 1'b1, 16'd4849, 32'd26);
    push_tick(1'b0, 1'b1, 16'd4000, 32'd31);
    push_tick(1'b0, 1'b1, 16'hFFFF, 32'd32);
    push_tick(1'b0, 1'b1, 16'hFFFF, 32'd33);
    push_tick(1'b1, 1'b0, 16'd0, 32'd34);
    push_tick(1'b0, 1'b1, 16'd0, 32'hFFFF_FFFE);
    push_tick(1'b0, 1'b1, 16'd0, 32'h0000_0002);
    push_tick(1'b0, 1'b1, 16'd0, 32'h0000_0003);
    push_tick(1'b0, 1'b0, 16'd0, 32'h8000_0000);
    settle();

    program_limits(5000, 2200, 1, 5, 3, 0, 1023);
    random_phase(PHASE_TICKS, 32'd1000);
    settle();
    program_limits(12000, 500, 16'hFFFF, 0, 0, 2, 9);
    random_phase(PHASE_TICKS, 32'hFFFF_FF80);
    settle();
    program_limits(3000, 0, 0, 8'hFF, 100, 0, 1023);
    random_phase(PHASE_TICKS, $urandom);
    settle();
    program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 50, 5, 3);
    random_phase(PHASE_TICKS, $urandom);
    settle();
    program_limits(0, 0, 200, 2, 127, 0, 0);
    random_phase(PHASE_TICKS, $urandom);
    settle();
    program_limits(8000, 1000, 20, 3, 10, 100, 140);
    random_phase(PHASE_TICKS, $urandom);
    settle();
    lo_duty = $urandom_range(0, 20);
    program_limits($urandom_range(1000, 40000), $urandom_range(0, 5000),
                   $urandom_range(0, 100), $urandom_range(0, 8), $urandom_range(0, 60),
                   lo_duty, lo_duty + $urandom_range(0, 60));
    random_phase(PHASE_TICKS, $urandom);
    settle();
    program_limits(1500, 300, 5, 1, 0, 1023, 1023);
    random_phase(PHASE_TICKS, $urandom);
    settle();

    $display("%0d words sent over %0d register settings, %0d results checked",
             ticks_taken, settings, outputs_seen);
    $display("%0d overvoltage snubs and %0d restarts seen, %0d mismatches",
             snubs, restarts, errors);
    if (errors == 0) begin
      $display("[cv_duty_regulator_softstart] OK");
    end else begin
      $display("[cv_duty_regulator_softstart] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/cvdr_pkg.sv
design/cvdr_if.sv
design/cv_duty_regulator_softstart.sv
design/cvdr_chk.sv
verif/tb_cv_duty_regulator_softstart.sv
